/* rtl/srl_pkg.sv */
// shared types, widths and helpers for the sprinkler link response block
// no dependencies
package srl_pkg;

  localparam int NumSprinklersDef = 16;

  // field widths
  localparam int IdxW     = 4;
  localparam int SpeedW   = 16;
  localparam int TempW    = 16;
  localparam int StepW    = 16;
  localparam int RtiW     = 10;
  localparam int CondW    = 12;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 56;
  localparam int OutDataW = 24;

  // internal widths
  localparam int DteW   = 24;
  localparam int RadW   = 40;
  localparam int RootW  = 20;
  localparam int LinkW  = 26;
  localparam int InnerW = 47;
  localparam int MagW   = 46;
  localparam int NumW   = 63;
  localparam int DivW   = 31;

  // reset values of the configuration registers
  localparam logic [RtiW-1:0]  RtiRst  = 10'd200;
  localparam logic [CondW-1:0] CondRst = 12'd0;
  localparam logic [TempW-1:0] ActRst  = 16'd27648;
  localparam logic [TempW-1:0] T0Rst   = 16'd19082;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RTI  = 8'd0,
    REG_COND = 8'd1,
    REG_ACT  = 8'd2,
    REG_T0   = 8'd3
  } srl_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL,
    ST_NUM,
    ST_DIV,
    ST_FIN
  } srl_state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic num_en;
    logic commit;
  } srl_cmd_t;

  typedef struct packed {
    logic skip;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } srl_sts_t;

  // link temperature in 1/4096 K to 1/64 K, rounded and saturated
  function automatic logic [TempW-1:0] to_output(input logic signed [LinkW-1:0] lq);
    logic [LinkW-1:0] t;
    logic [TempW-1:0] r;
    t = LinkW'(lq + LinkW'(32)) >> 6;
    if (lq < 0) begin
      r = '0;
    end else if (t > LinkW'(16'hFFFF)) begin
      r = '1;
    end else begin
      r = t[TempW-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/srl_sqrt.sv */
// iterative integer square root, two radicand bits per cycle
// depends on srl_pkg
module srl_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [srl_pkg::RadW-1:0]    radicand_i,
  output logic                        busy_o,
  output logic [srl_pkg::RootW-1:0]   root_o
);
  import srl_pkg::*;

  localparam int CntW = $clog2(RootW);

  logic [RadW-1:0]    rad_q, rad_d;
  logic [RootW+1:0]   rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [RootW+3:0]   rem_sh;
  logic [RootW+3:0]   trial;

  // one digit step
  always_comb begin
    rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = (RootW+2)'(rem_sh - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = (RootW+2)'(rem_sh);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

/* rtl/srl_div.sv */
// restoring divider, one quotient bit per cycle
// depends on srl_pkg
module srl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [srl_pkg::DivW-1:0]   dividend_i,
  input  logic [srl_pkg::RtiW-1:0]   divisor_i,
  output logic                       busy_o,
  output logic [srl_pkg::DivW-1:0]   quotient_o
);
  import srl_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic [DivW-1:0] quo_q, quo_d;
  logic [RtiW-1:0] rem_q, rem_d;
  logic [RtiW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [RtiW:0]   rem_sh;
  logic            qbit;

  // one quotient bit step
  always_comb begin
    rem_sh = {rem_q, quo_q[DivW-1]};
    qbit   = rem_sh >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = (divisor_i == '0) ? RtiW'(1) : divisor_i;
      cnt_d  = CntW'(DivW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = qbit ? RtiW'(rem_sh - {1'b0, dvs_q}) : RtiW'(rem_sh);
      quo_d  = {quo_q[DivW-2:0], qbit};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/srl_ctrl.sv */
// controller state machine sequencing one sample through the datapath
// depends on srl_pkg
module srl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srl_pkg::srl_sts_t sts_i,
  output srl_pkg::srl_cmd_t cmd_o
);
  import srl_pkg::*;

  srl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts_i.skip) begin
          state_d = ST_FIN;
        end else if (sts_i.sqrt_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num_en = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/srl_dp.sv */
// datapath: registers, per-sprinkler store, rti update arithmetic, output register
// depends on srl_pkg, srl_sqrt, srl_div
module srl_dp #(
  parameter int NumSprinklers = srl_pkg::NumSprinklersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [srl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [srl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [srl_pkg::InDataW-1:0]   in_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [srl_pkg::OutDataW-1:0]  out_data_o,
  input  srl_pkg::srl_cmd_t             cmd_i,
  output srl_pkg::srl_sts_t             sts_o
);
  import srl_pkg::*;

  localparam int AddrW = (NumSprinklers > 1) ? $clog2(NumSprinklers) : 1;
  localparam int ExtW  = AddrW + IdxW;

  // configuration registers
  logic [RtiW-1:0]  rti_q;
  logic [CondW-1:0] cond_q;
  logic [TempW-1:0] act_q;
  logic [TempW-1:0] t0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rti_q  <= RtiRst;
      cond_q <= CondRst;
      act_q  <= ActRst;
      t0_q   <= T0Rst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RTI:  rti_q  <= cfg_data_i[RtiW-1:0];
        REG_COND: cond_q <= cfg_data_i[CondW-1:0];
        REG_ACT:  act_q  <= cfg_data_i;
        REG_T0:   t0_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic [IdxW-1:0]   in_idx;
  logic [SpeedW-1:0] in_speed;
  logic [TempW-1:0]  in_tg;
  logic [StepW-1:0]  in_dt;
  logic [ExtW-1:0]   in_ext;
  logic [AddrW-1:0]  in_addr;
  logic              in_oor;

  assign in_idx   = in_data_i[IdxW-1:0];
  assign in_speed = in_data_i[IdxW +: SpeedW];
  assign in_tg    = in_data_i[IdxW+SpeedW +: TempW];
  assign in_dt    = in_data_i[IdxW+SpeedW+TempW +: StepW];
  assign in_ext   = {{AddrW{1'b0}}, in_idx};
  assign in_addr  = in_ext[AddrW-1:0];
  assign in_oor   = in_ext >= ExtW'(NumSprinklers);

  // per-sprinkler store
  logic signed [DteW-1:0] dte_mem_q [NumSprinklers];
  logic [NumSprinklers-1:0] flag_q;

  // captured sample
  logic [AddrW-1:0]       addr_q;
  logic                   oor_q;
  logic                   done_q;
  logic signed [DteW-1:0] dte_q;
  logic [TempW-1:0]       tg_q;
  logic [StepW-1:0]       dt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= in_addr;
      oor_q  <= in_oor;
      done_q <= in_oor ? 1'b0 : flag_q[in_addr];
      dte_q  <= dte_mem_q[in_addr];
      tg_q   <= in_tg;
      dt_q   <= in_dt;
    end
  end

  // square root of the speed, Q12
  logic             sqrt_busy;
  logic [RootW-1:0] root;

  srl_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .radicand_i ({in_speed, 24'd0}),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // inner term: s*(dtg - dte) - c*dte*256
  logic signed [TempW:0]    dtg_k;
  logic signed [DteW:0]     diff;
  logic signed [InnerW-1:0] prod_s;
  logic signed [InnerW-1:0] prod_c;
  logic signed [InnerW-1:0] inner_q;

  always_comb begin
    dtg_k  = $signed({1'b0, tg_q}) - $signed({1'b0, t0_q});
    diff   = (DteW+1)'($signed({dtg_k, 6'd0})) - (DteW+1)'(dte_q);
    prod_s = InnerW'($signed({1'b0, root})) * InnerW'(diff);
    prod_c = (InnerW'($signed({1'b0, cond_q})) * InnerW'(dte_q)) <<< 8;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      inner_q <= prod_s - prod_c;
    end
  end

  // magnitude times step, plus half the divisor scale
  logic            neg_q;
  logic [MagW-1:0] mag;
  logic [NumW-1:0] num;

  always_comb begin
    mag = inner_q[InnerW-1] ? MagW'(-inner_q) : MagW'(inner_q);
    num = NumW'(mag) * NumW'(dt_q) + (NumW'(rti_q == '0 ? RtiW'(1) : rti_q) << 31);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.num_en) begin
      neg_q <= inner_q[InnerW-1];
    end
  end

  logic            div_busy;
  logic [DivW-1:0] quo;

  srl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.num_en),
    .dividend_i (num[NumW-1 -: DivW]),
    .divisor_i  (rti_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // new excess, link temperature and activation test
  logic signed [DivW+1:0]  qs;
  logic signed [DivW+1:0]  nd_full;
  logic signed [DteW-1:0]  nd_sat;
  logic signed [DteW-1:0]  dte_new;
  logic signed [LinkW-1:0] lq;
  logic                    fire;
  logic [TempW-1:0]        link;

  always_comb begin
    qs      = $signed({2'b00, quo});
    nd_full = (DivW+2)'(dte_q) + (neg_q ? -qs : qs);
    if (nd_full > (DivW+2)'(24'sh7FFFFF)) begin
      nd_sat = 24'sh7FFFFF;
    end else if (nd_full < -(DivW+2)'(25'sh0800000)) begin
      nd_sat = 24'sh800000;
    end else begin
      nd_sat = nd_full[DteW-1:0];
    end
    dte_new = done_q ? dte_q : nd_sat;
    lq      = $signed({4'd0, t0_q, 6'd0}) + LinkW'(dte_new);
    fire    = !done_q && (lq > $signed({4'd0, act_q, 6'd0}));
    link    = to_output(lq);
  end

  // store write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
      for (int i = 0; i < NumSprinklers; i++) begin
        dte_mem_q[i] <= '0;
      end
    end else if (cmd_i.commit && !oor_q && !done_q) begin
      dte_mem_q[addr_q] <= nd_sat;
      flag_q[addr_q]    <= fire;
    end
  end

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (oor_q) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {6'd0, fire, done_q | fire, link};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.skip      = oor_q || done_q;
  assign sts_o.sqrt_done = !sqrt_busy;
  assign sts_o.div_done  = !div_busy;
  assign sts_o.out_free  = out_free;

endmodule

/* rtl/sprinkler_link_rti_response_top.sv */
// top level of the sprinkler link rti response block
// depends on srl_pkg, srl_ctrl, srl_dp (with srl_sqrt, srl_div)
//
//  channel   direction  transaction on            payload
//  s_axis    in         s_axis_tvalid & tready    one sample of one sprinkler
//  m_axis    out        m_axis_tvalid & tready    link temperature and flags
//  cfg       in         cfg_valid_i & cfg_ready_o register index and data
//
// an updated sample is taken in the idle state, then passes the square root (20 bit-pair
// steps), a multiply state, a numerator state, the divider (31 quotient bits) and a finish state
// activated or out-of-range sprinklers go from the square root state straight to the finish state
// reset clears all link excess temperatures and activation flags at once
// the finish cycle stalls while the output register holds an unaccepted result
// a new sample is taken while the previous result waits in the output register
module sprinkler_link_rti_response_top #(
  parameter int NumSprinklers = srl_pkg::NumSprinklersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sprinkler_index[3:0], gas_speed[19:4], gas_temperature[35:20], step_length[51:36]
  input  logic [srl_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // link_temperature[15:0], is_activated[16], just_activated[17]
  output logic [srl_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [srl_pkg::CfgDataW-1:0]  cfg_data_i
);
  import srl_pkg::*;

  srl_cmd_t cmd;
  srl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  srl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srl_dp #(
    .NumSprinklers (NumSprinklers)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* dv/tb_sprinkler_link_rti_response_top.sv */
// self-checking testbench for the sprinkler link rti response block
// depends on srl_pkg and sprinkler_link_rti_response_top; keeps its own link temperature model
module tb_sprinkler_link_rti_response_top;
  import srl_pkg::*;

  localparam int DrainCycles = 100;
  localparam int StallLimit  = 20000;
  localparam logic [CfgIdxW-1:0] RegUnused = 8'hA5;

  typedef struct {
    logic [IdxW-1:0]   sprinkler;
    logic [SpeedW-1:0] speed;
    logic [TempW-1:0]  gas_temp;
    logic [StepW-1:0]  step;
  } sample_t;

  typedef struct {
    logic [TempW-1:0] link_temp;
    logic             activated;
    logic             fresh;
  } link_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  sprinkler_link_rti_response_top uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model copy of registers and per-sprinkler state
  logic [RtiW-1:0]  m_rti;
  logic [CondW-1:0] m_cond;
  logic [TempW-1:0] m_act_thr;
  logic [TempW-1:0] m_t0;
  longint           m_excess [NumSprinklersDef];
  bit               m_fired  [NumSprinklersDef];

  sample_t      pending_samples[$];
  link_result_t expected_links[$];
  sample_t      on_bus;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           mismatches;
  int           quiet_cycles;

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bit_val;
    res = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > v) bit_val >>= 2;
    while (bit_val != 0) begin
      if (v >= res + bit_val) begin
        v -= res + bit_val;
        res = (res >> 1) + bit_val;
      end else begin
        res >>= 1;
      end
      bit_val >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [TempW-1:0] q12_to_temp(longint q12);
    longint t;
    if (q12 < 0) return '0;
    t = (q12 + 32) / 64;
    if (t > 65535) t = 65535;
    return t[TempW-1:0];
  endfunction

  // advance the link excess temperature of one sprinkler by one rti step
  function automatic link_result_t link_step(sample_t smp);
    link_result_t r;
    longint s, dte, dtg, inner, q, nd, lq;
    longint unsigned mag, num, den, rti;
    bit neg;
    dte = m_excess[smp.sprinkler];
    r.fresh = 1'b0;
    if (m_fired[smp.sprinkler]) begin
      r.link_temp = q12_to_temp(longint'(m_t0) * 64 + dte);
      r.activated = 1'b1;
      return r;
    end
    s = root_floor(longint'(smp.speed) << 24);
    dtg = (longint'(smp.gas_temp) - longint'(m_t0)) * 64;
    inner = s * (dtg - dte) - longint'(m_cond) * dte * 256;
    neg = inner < 0;
    mag = neg ? -inner : inner;
    num = mag * longint'(smp.step);
    rti = (m_rti == 0) ? 1 : m_rti;
    den = rti << 32;
    q = longint'((num + (den >> 1)) / den);
    if (neg) q = -q;
    nd = dte + q;
    if (nd > 8388607) nd = 8388607;
    if (nd < -8388608) nd = -8388608;
    m_excess[smp.sprinkler] = nd;
    lq = longint'(m_t0) * 64 + nd;
    r.link_temp = q12_to_temp(lq);
    r.activated = lq > longint'(m_act_thr) * 64;
    r.fresh = r.activated;
    if (r.activated) m_fired[smp.sprinkler] = 1'b1;
    return r;
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) expected_links.push_back(link_step(on_bus));
      if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_samples.pop_front();
          s_axis_tdata <= {4'd0, on_bus.step, on_bus.gas_temp, on_bus.speed, on_bus.sprinkler};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    link_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_links.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_links.pop_front();
          if (m_axis_tdata[15:0] !== want.link_temp) begin
            $error("link_temperature expected %0d actual %0d", want.link_temp,
                   m_axis_tdata[15:0]);
            mismatches++;
          end
          if (m_axis_tdata[16] !== want.activated) begin
            $error("is_activated expected %0d actual %0d", want.activated, m_axis_tdata[16]);
            mismatches++;
          end
          if (m_axis_tdata[17] !== want.fresh) begin
            $error("just_activated expected %0d actual %0d", want.fresh, m_axis_tdata[17]);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RTI:  m_rti = val[RtiW-1:0];
      REG_COND: m_cond = val[CondW-1:0];
      REG_ACT:  m_act_thr = val;
      REG_T0:   m_t0 = val;
      default: ;
    endcase
  endtask

  task automatic configure(int rti, int cond, int act, int t0);
    write_reg(REG_RTI, CfgDataW'(rti));
    write_reg(REG_COND, CfgDataW'(cond));
    write_reg(REG_ACT, CfgDataW'(act));
    write_reg(REG_T0, CfgDataW'(t0));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // waits until every queued sample is sent and every expected result is back
  task automatic drain();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_links.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_sample(int idx, int spd, int tg, int dt);
    sample_t smp;
    smp.sprinkler = IdxW'(idx);
    smp.speed = SpeedW'(spd);
    smp.gas_temp = TempW'(tg);
    smp.step = StepW'(dt);
    pending_samples.push_back(smp);
  endtask

  // mostly small steps near t0 so sprinklers heat over many samples
  task automatic add_random_sample();
    int tg, dt, spd;
    spd = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2048);
    tg = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                  : int'(m_t0) + $urandom_range(4000) - 1500;
    if (tg < 0) tg = 0;
    if (tg > 65535) tg = 65535;
    dt = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(3000);
    add_sample($urandom_range(15), spd, tg, dt);
  endtask

  initial begin
    int settings [5][4];
    settings = '{'{1023, 0, 65535, 0}, '{200, 256, 27648, 19082},
                 '{50, 4095, 40000, 10000}, '{1, 100, 30000, 20000},
                 '{0, 4095, 0, 65535}};
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 17;
    recv_stall_pct = 71;
    m_rti = RtiRst;
    m_cond = CondRst;
    m_act_thr = ActRst;
    m_t0 = T0Rst;
    for (int i = 0; i < NumSprinklersDef; i++) begin
      m_excess[i] = 0;
      m_fired[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes under reset registers
    add_sample(0, 0, 0, 65535);
    add_sample(0, 65535, 0, 65535);
    add_sample(1, 65535, 65535, 0);
    add_sample(1, 0, 65535, 65535);
    add_sample(2, 65535, 65535, 65535);
    add_sample(2, 65535, 65535, 65535);
    add_sample(15, 256, 30000, 20000);
    add_sample(15, 65535, 65535, 65535);
    add_sample(15, 100, 0, 100);
    drain();
    // unlisted register index is ignored, then zero rti and full conduction
    write_reg(RegUnused, 16'hFFFF);
    configure(0, 4095, 65535, 1000);
    add_sample(3, 0, 0, 65535);
    add_sample(3, 0, 65535, 65535);
    add_sample(4, 65535, 0, 65535);
    add_sample(4, 65535, 0, 65535);
    add_sample(5, 65535, 65535, 65535);
    add_sample(5, 1, 65535, 1);
    add_sample(2, 300, 100, 300);
    drain();

    for (int p = 0; p < 5; p++) begin
      if (p == 2) begin
        send_idle_pct = 71;
        recv_stall_pct = 17;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      configure(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
      for (int chunk = 0; chunk < 5; chunk++) begin
        for (int n = 0; n < 52; n++) add_random_sample();
        if (chunk == 2) drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
